>>> rtl/core/additive_lagged_fibonacci_prng_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lagged Fibonacci generator core
// Implication checks, same cycle and next cycle, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_LAGGED_FIBONACCI_PRNG_CORE_ASSERT_SVH
`define ADDITIVE_LAGGED_FIBONACCI_PRNG_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define ALFP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the following cycle
`define ALFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/alfp_pkg.sv
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared constants for the additive lagged Fibonacci generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alfp_pkg;

    localparam int WORD_W     = 32;
    localparam int LONG_LAG   = 31;
    localparam int SHORT_LAG  = 3;
    localparam int MOD_W      = 31;
    localparam int MULT_W     = 15;
    localparam int S_TDATA_W  = 8;

    localparam logic [MULT_W-1:0] MULT_CONST = 15'd16807;
    localparam logic [MOD_W-1:0]  MOD_PRIME  = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

>>> rtl/core/alfp_mulmod.sv
// ----------------------------------------------------------------------------
// alfp_mulmod
// Signed word times 16807, remainder mod 2^31-1 raised to non-negative.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfp_mulmod (
    input  wire logic [alfp_pkg::WORD_W-1:0] prev_word,
    output logic      [alfp_pkg::WORD_W-1:0] next_word
);

    localparam int PROD_W = alfp_pkg::WORD_W + alfp_pkg::MULT_W;
    localparam int HI_W   = PROD_W - alfp_pkg::MOD_W;

    logic                          neg;
    logic [alfp_pkg::WORD_W-1:0]   mag;
    logic [PROD_W-1:0]             prod;
    logic [alfp_pkg::WORD_W-1:0]   fold;
    logic [alfp_pkg::WORD_W-1:0]   red;
    logic [alfp_pkg::MOD_W-1:0]    rem;

    assign neg  = prev_word[alfp_pkg::WORD_W-1];
    assign mag  = neg ? (~prev_word + 1'b1) : prev_word;
    assign prod = PROD_W'(mag) * PROD_W'(alfp_pkg::MULT_CONST);

    // 2^31 == 1 mod (2^31-1): fold high part onto low part
    assign fold = {1'b0, prod[alfp_pkg::MOD_W-1:0]}
                + alfp_pkg::WORD_W'(prod[PROD_W-1 -: HI_W]);
    assign red  = (fold >= {1'b0, alfp_pkg::MOD_PRIME})
                ? (fold - {1'b0, alfp_pkg::MOD_PRIME}) : fold;
    assign rem  = red[alfp_pkg::MOD_W-1:0];

    always_comb begin
        if (neg && (rem != '0)) begin
            next_word = {1'b0, alfp_pkg::MOD_PRIME - rem};
        end else begin
            next_word = {1'b0, rem};
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/alfp_hist_ram.sv
// ----------------------------------------------------------------------------
// alfp_hist_ram
// Word history memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfp_hist_ram #(
    parameter int DEPTH  = alfp_pkg::LONG_LAG,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [alfp_pkg::WORD_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [alfp_pkg::WORD_W-1:0] rd_data
);

    logic [alfp_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/alfp_out_buf.sv
// ----------------------------------------------------------------------------
// alfp_out_buf
// Two-entry output register with skid slot for the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alfp_out_buf (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire logic [alfp_pkg::WORD_W-1:0] push_data,
    output logic                             full,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [alfp_pkg::WORD_W-1:0] m_tdata
);

    logic                        main_valid_reg, main_valid_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic [alfp_pkg::WORD_W-1:0] main_data_reg,  main_data_next;
    logic [alfp_pkg::WORD_W-1:0] skid_data_reg,  skid_data_next;
    logic                        pop;

    assign pop      = main_valid_reg & m_tready;
    assign full     = skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/additive_lagged_fibonacci_prng_core.sv
// ----------------------------------------------------------------------------
// additive_lagged_fibonacci_prng_core
// Additive lagged Fibonacci word generator, random() type 3 sequence.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the seed (word 0); cfg_ready is always
//   high. Write it only while the core is idle.
//   Each s_ transaction requests one word; s_tdata[0] = restart starts the
//   sequence over and returns the seed. Each request gives one m_ transaction
//   carrying the 32-bit word.
//   Output: the word goes into the registered output stage and then onto m_tdata.
//   Throughput: one word per cycle while s_tready is high. The long-lag
//   history sits in a 31-entry RAM read one item ahead; the short lag and the
//   previous word sit in registers; the 16807 multiply-mod is combinational.
//   Reset: seed becomes 1, next word is word 0; no clearing pass is needed.
//   Stall: a two-entry output stage keeps s_tready high while one result
//   waits; s_tready drops only when two results are pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "additive_lagged_fibonacci_prng_core_assert.svh"

module additive_lagged_fibonacci_prng_core #(
    parameter int LONG_LAG = alfp_pkg::LONG_LAG
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // config: seed_value
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [alfp_pkg::WORD_W-1:0]    cfg_data,
    // s_tdata: [0] restart, [7:1] zero
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [alfp_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: [31:0] word_out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [alfp_pkg::WORD_W-1:0]    m_tdata
);

    localparam int ADD_PHASE = LONG_LAG + alfp_pkg::SHORT_LAG;
    localparam int POS_W     = $clog2(ADD_PHASE + 1);
    localparam int PTR_W     = $clog2(LONG_LAG);

    logic                        s_acc;
    logic                        restart;
    logic                        buf_full;
    logic [alfp_pkg::WORD_W-1:0] seed_reg;
    logic [POS_W-1:0]            pos_reg, pos_next, pos_cur;
    logic [PTR_W-1:0]            wp_reg, wp_cur, wp_adv;
    logic [alfp_pkg::WORD_W-1:0] lag1_reg, lag2_reg, lag3_reg;
    logic [alfp_pkg::WORD_W-1:0] long_q;
    logic [alfp_pkg::WORD_W-1:0] mul_word;
    logic [alfp_pkg::WORD_W-1:0] word;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~buf_full;
    assign s_acc     = s_tvalid & s_tready;
    assign restart   = s_tdata[0];

    assign pos_cur = restart ? '0 : pos_reg;
    assign wp_cur  = restart ? '0 : wp_reg;
    assign wp_adv  = (wp_cur == PTR_W'(LONG_LAG - 1)) ? '0 : wp_cur + 1'b1;

    alfp_mulmod u_mulmod (
        .prev_word (lag1_reg),
        .next_word (mul_word)
    );

    alfp_hist_ram #(
        .DEPTH  (LONG_LAG),
        .ADDR_W (PTR_W)
    ) u_hist_ram (
        .aclk    (aclk),
        .wr_en   (s_acc),
        .wr_addr (wp_cur),
        .wr_data (word),
        .rd_en   (s_acc),
        .rd_addr (wp_adv),
        .rd_data (long_q)
    );

    always_comb begin
        if (pos_cur == '0) begin
            word = seed_reg;
        end else if (pos_cur < POS_W'(LONG_LAG)) begin
            word = mul_word;
        end else if (pos_cur < POS_W'(ADD_PHASE)) begin
            word = long_q;
        end else begin
            word = long_q + lag3_reg;
        end
    end

    assign pos_next = (pos_cur < POS_W'(ADD_PHASE)) ? pos_cur + 1'b1 : pos_cur;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= alfp_pkg::WORD_W'(1);
            pos_reg  <= '0;
            wp_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_data;
            end
            if (s_acc) begin
                pos_reg <= pos_next;
                wp_reg  <= wp_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            lag1_reg <= word;
            lag2_reg <= lag1_reg;
            lag3_reg <= lag2_reg;
        end
    end

    alfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_acc),
        .push_data (word),
        .full      (buf_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `ALFP_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready,
        "input stalled with empty output stage")
    `ALFP_ASSERT_NEXT(a_restart_pos, aclk, aresetn, s_acc && restart,
        (pos_reg == POS_W'(1)) && (wp_reg == PTR_W'(1)), "restart did not rewind")
    `ALFP_ASSERT_SAME(a_pos_range, aclk, aresetn, 1'b1,
        (pos_reg <= POS_W'(ADD_PHASE)) && (wp_reg < PTR_W'(LONG_LAG)),
        "position or pointer out of range")
    `ALFP_ASSERT_NEXT(a_result_shown, aclk, aresetn, s_acc, m_tvalid,
        "accepted transaction left no result")

endmodule

`default_nettype wire
